>>> rtl/core/buddy_allocator_core_assert.svh
// Assertion macros for the checker file of the buddy allocator.
`ifndef BUDDY_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_ALLOCATOR_CORE_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define BA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define BA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/core/ba_pkg.sv
// Shared constants, codes, types and a helper function of the buddy allocator.
package ba_pkg;

   localparam int POOL_ORDER = 10;
   localparam int SIZE_W     = 11;
   localparam int OFF_W      = 10;
   localparam int STAT_W     = 2;
   localparam int LVL_W      = $clog2(POOL_ORDER + 1);
   localparam int NODE_W     = POOL_ORDER;
   localparam int WORD_LG    = (POOL_ORDER > 5) ? 5 : POOL_ORDER - 1;
   localparam int WORD_W     = 1 << WORD_LG;
   localparam int ROW_W      = POOL_ORDER - WORD_LG;
   localparam int ROWS       = 1 << ROW_W;
   localparam int GR_AW      = POOL_ORDER - 1;
   localparam int GRANULES   = 1 << GR_AW;
   localparam int CNT_W      = POOL_ORDER;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADSIZE = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADADDR = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic              clr_step;
      logic              load_req;
      logic              alloc_init;
      logic              scan_rd;
      logic              scan_next;
      logic              scan_take;
      logic              split_step;
      logic              buddy;
      logic              map_set;
      logic              map_clr;
      logic              merge_step;
      logic              free_init;
      logic              gran_alloc;
      logic              set_status;
      logic [STAT_W-1:0] status_code;
      logic              finish;
   } ba_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic bad_size;
      logic no_level;
      logic at_k;
      logic scan_hit;
      logic bad_off;
      logic gran_bad;
      logic at_top;
      logic node_free;
      logic rsp_free;
   } ba_stat_type;

   // Heap index of the first node of a level; the root is node one.
   function automatic logic [NODE_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
      logic [31:0] base;
      base = 32'(1) << (POOL_ORDER - int'(lvl));
      return base[NODE_W-1:0];
   endfunction

endpackage

>>> rtl/core/ba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ba_ctrl.sv
// Controller state machine that sequences the allocate and free walks.
module ba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_func,
   output logic                 req_tready,
   input  ba_pkg::ba_stat_type  stat,
   output ba_pkg::ba_cmd_type   cmd
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_ALLOC_CHK = 4'd2;
   localparam logic [3:0] S_SCAN_RD   = 4'd3;
   localparam logic [3:0] S_SCAN_CHK  = 4'd4;
   localparam logic [3:0] S_SPLIT     = 4'd5;
   localparam logic [3:0] S_SPLIT_RD  = 4'd6;
   localparam logic [3:0] S_SPLIT_WR  = 4'd7;
   localparam logic [3:0] S_GRAN_WR   = 4'd8;
   localparam logic [3:0] S_FREE_RD   = 4'd9;
   localparam logic [3:0] S_FREE_CHK  = 4'd10;
   localparam logic [3:0] S_MERGE     = 4'd11;
   localparam logic [3:0] S_MERGE_CHK = 4'd12;
   localparam logic [3:0] S_SET_RD    = 4'd13;
   localparam logic [3:0] S_SET_WR    = 4'd14;
   localparam logic [3:0] S_DONE      = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = (req_func == ba_pkg::FUNC_FREE) ? S_FREE_RD : S_ALLOC_CHK;
            end
         end
         S_ALLOC_CHK: begin
            if (stat.bad_size) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ba_pkg::ST_BADSIZE;
               state_in = S_DONE;
            end else if (stat.no_level) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ba_pkg::ST_NOSPACE;
               state_in = S_DONE;
            end else begin
               cmd.alloc_init = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (stat.scan_hit) begin
               cmd.scan_take = 1'b1;
               state_in = S_SPLIT;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SPLIT: begin
            if (stat.at_k) begin
               state_in = S_GRAN_WR;
            end else begin
               cmd.split_step = 1'b1;
               state_in = S_SPLIT_RD;
            end
         end
         S_SPLIT_RD: begin
            cmd.buddy = 1'b1;
            state_in = S_SPLIT_WR;
         end
         S_SPLIT_WR: begin
            cmd.buddy   = 1'b1;
            cmd.map_set = 1'b1;
            state_in = S_SPLIT;
         end
         S_GRAN_WR: begin
            cmd.gran_alloc  = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ba_pkg::ST_OK;
            state_in = S_DONE;
         end
         S_FREE_RD: begin
            if (stat.bad_off) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ba_pkg::ST_BADADDR;
               state_in = S_DONE;
            end else begin
               state_in = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            if (stat.gran_bad) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ba_pkg::ST_BADADDR;
               state_in = S_DONE;
            end else begin
               cmd.free_init = 1'b1;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            cmd.buddy = 1'b1;
            state_in = stat.at_top ? S_SET_RD : S_MERGE_CHK;
         end
         S_MERGE_CHK: begin
            cmd.buddy = 1'b1;
            if (stat.node_free) begin
               cmd.map_clr    = 1'b1;
               cmd.merge_step = 1'b1;
               state_in = S_MERGE;
            end else begin
               state_in = S_SET_RD;
            end
         end
         S_SET_RD: begin
            state_in = S_SET_WR;
         end
         S_SET_WR: begin
            cmd.map_set     = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ba_pkg::ST_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/ba_datapath.sv
// Datapath with the node map, the granule level store, level counts and result register.
module ba_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ba_pkg::ba_cmd_type           cmd,
   output ba_pkg::ba_stat_type          stat,
   input  logic                         req_func,
   input  logic [ba_pkg::SIZE_W-1:0]    req_size,
   input  logic [ba_pkg::OFF_W-1:0]     req_offset,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ba_pkg::OFF_W-1:0]     rsp_block_offset,
   output logic [ba_pkg::STAT_W-1:0]    rsp_status
);

   localparam int NW = ba_pkg::NODE_W;
   localparam int LW = ba_pkg::LVL_W;
   localparam int PO = ba_pkg::POOL_ORDER;

   logic                        func_ff, func_in;
   logic [ba_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [ba_pkg::OFF_W-1:0]    offset_ff, offset_in;
   logic [LW-1:0]               k_ff, k_in;
   logic [LW-1:0]               lvl_ff, lvl_in;
   logic [NW-1:0]               idx_ff, idx_in;
   logic [ba_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [ba_pkg::OFF_W-1:0]    res_off_ff, res_off_in;
   logic [ba_pkg::STAT_W-1:0]   status_ff, status_in;
   logic [ba_pkg::GR_AW-1:0]    clr_ff, clr_in;
   logic [ba_pkg::CNT_W-1:0]    cnt_ff [1:PO];
   logic [ba_pkg::CNT_W-1:0]    cnt_in [1:PO];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ba_pkg::OFF_W-1:0]    rsp_off_ff, rsp_off_in;
   logic [ba_pkg::STAT_W-1:0]   rsp_stat_ff, rsp_stat_in;

   logic                        map_we;
   logic [ba_pkg::ROW_W-1:0]    map_waddr, map_raddr;
   logic [ba_pkg::WORD_W-1:0]   map_wdata, map_rdata;
   logic                        gran_we;
   logic [ba_pkg::GR_AW-1:0]    gran_waddr, gran_raddr;
   logic [LW-1:0]               gran_wdata, gran_rdata;

   logic [NW-1:0]               node;
   logic [ba_pkg::ROW_W-1:0]    node_row;
   logic [ba_pkg::WORD_LG-1:0]  node_bit;
   logic [ba_pkg::WORD_W-1:0]   hit_vec;
   logic [ba_pkg::WORD_LG-1:0]  scan_bit;
   logic [NW-1:0]               scan_node;
   logic [NW-1:0]               alloc_off;
   logic [LW-1:0]               k_calc;
   logic [LW-1:0]               fit_lvl;
   logic                        fit_found;
   logic [NW-1:0]               fit_base;

   ba_ram #(.WIDTH(ba_pkg::WORD_W), .DEPTH(ba_pkg::ROWS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   ba_ram #(.WIDTH(LW), .DEPTH(ba_pkg::GRANULES)) u_gran_ram (
      .clock   (clock),
      .wr_en   (gran_we),
      .wr_addr (gran_waddr),
      .wr_data (gran_wdata),
      .rd_addr (gran_raddr),
      .rd_data (gran_rdata)
   );

   assign node      = ba_pkg::level_base(lvl_ff) | (idx_ff ^ NW'(cmd.buddy));
   assign node_row  = node[NW-1:ba_pkg::WORD_LG];
   assign node_bit  = node[ba_pkg::WORD_LG-1:0];
   assign map_raddr = cmd.scan_rd ? row_ff : node_row;
   assign gran_raddr = offset_ff[ba_pkg::GR_AW:1];
   assign alloc_off = NW'(32'(idx_ff) << k_ff);
   assign scan_node = {row_ff, scan_bit};
   assign fit_base  = ba_pkg::level_base(fit_lvl);

   always_comb begin
      logic [NW-1:0] h_node;
      hit_vec  = '0;
      scan_bit = '0;
      for (int b = 0; b < ba_pkg::WORD_W; b++) begin
         h_node = {row_ff, ba_pkg::WORD_LG'(b)};
         hit_vec[b] = map_rdata[b] && ((h_node >> (PO - int'(lvl_ff))) == NW'(1));
      end
      for (int b = ba_pkg::WORD_W - 1; b >= 0; b--) begin
         if (hit_vec[b]) begin
            scan_bit = ba_pkg::WORD_LG'(b);
         end
      end
   end

   always_comb begin
      k_calc    = LW'(1);
      fit_lvl   = '0;
      fit_found = 1'b0;
      for (int i = PO; i >= 1; i--) begin
         if (32'(size_ff) <= (32'(1) << i)) begin
            k_calc = LW'(i);
         end
      end
      for (int o = PO; o >= 1; o--) begin
         if (o >= int'(k_calc) && cnt_ff[o] != '0) begin
            fit_lvl   = LW'(o);
            fit_found = 1'b1;
         end
      end
   end

   always_comb begin
      map_we    = 1'b0;
      map_waddr = node_row;
      map_wdata = map_rdata;
      if (cmd.clr_step) begin
         map_we    = ((clr_ff >> ba_pkg::ROW_W) == '0);
         map_waddr = clr_ff[ba_pkg::ROW_W-1:0];
         map_wdata = (clr_ff == '0) ? ba_pkg::WORD_W'(2) : '0;
      end else if (cmd.scan_take) begin
         map_we    = 1'b1;
         map_waddr = row_ff;
         map_wdata = map_rdata & ~(ba_pkg::WORD_W'(1) << scan_bit);
      end else if (cmd.map_set) begin
         map_we    = 1'b1;
         map_wdata = map_rdata | (ba_pkg::WORD_W'(1) << node_bit);
      end else if (cmd.map_clr) begin
         map_we    = 1'b1;
         map_wdata = map_rdata & ~(ba_pkg::WORD_W'(1) << node_bit);
      end
   end

   always_comb begin
      gran_we    = 1'b0;
      gran_waddr = offset_ff[ba_pkg::GR_AW:1];
      gran_wdata = '0;
      if (cmd.clr_step) begin
         gran_we    = 1'b1;
         gran_waddr = clr_ff;
      end else if (cmd.free_init) begin
         gran_we    = 1'b1;
      end else if (cmd.gran_alloc) begin
         gran_we    = 1'b1;
         gran_waddr = alloc_off[NW-1:1];
         gran_wdata = k_ff;
      end
   end

   always_comb begin
      func_in      = func_ff;
      size_in      = size_ff;
      offset_in    = offset_ff;
      k_in         = k_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      res_off_in   = res_off_ff;
      status_in    = status_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_off_in   = rsp_off_ff;
      rsp_stat_in  = rsp_stat_ff;
      for (int o = 1; o <= PO; o++) begin
         cnt_in[o] = cnt_ff[o];
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.load_req) begin
         func_in    = req_func;
         size_in    = req_size;
         offset_in  = req_offset;
         res_off_in = '0;
      end
      if (cmd.alloc_init) begin
         k_in   = k_calc;
         lvl_in = fit_lvl;
         row_in = fit_base[NW-1:ba_pkg::WORD_LG];
      end
      if (cmd.scan_next) begin
         row_in = row_ff + 1'b1;
      end
      if (cmd.scan_take) begin
         idx_in = scan_node & ~ba_pkg::level_base(lvl_ff);
         cnt_in[lvl_ff] = cnt_ff[lvl_ff] - 1'b1;
      end
      if (cmd.split_step) begin
         lvl_in = lvl_ff - 1'b1;
         idx_in = idx_ff << 1;
      end
      if (cmd.map_set) begin
         cnt_in[lvl_ff] = cnt_ff[lvl_ff] + 1'b1;
      end
      if (cmd.map_clr) begin
         cnt_in[lvl_ff] = cnt_ff[lvl_ff] - 1'b1;
      end
      if (cmd.merge_step) begin
         lvl_in = lvl_ff + 1'b1;
         idx_in = idx_ff >> 1;
      end
      if (cmd.free_init) begin
         lvl_in = gran_rdata;
         idx_in = NW'(32'(offset_ff) >> gran_rdata);
      end
      if (cmd.gran_alloc) begin
         res_off_in = ba_pkg::OFF_W'(alloc_off);
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_off_in   = (func_ff == ba_pkg::FUNC_ALLOC && status_ff == ba_pkg::ST_OK) ?
                        res_off_ff : '0;
         rsp_stat_in  = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int o = 1; o <= PO; o++) begin
            cnt_ff[o] <= (o == PO) ? ba_pkg::CNT_W'(1) : '0;
         end
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int o = 1; o <= PO; o++) begin
            cnt_ff[o] <= cnt_in[o];
         end
      end
      func_ff     <= func_in;
      size_ff     <= size_in;
      offset_ff   <= offset_in;
      k_ff        <= k_in;
      lvl_ff      <= lvl_in;
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      res_off_ff  <= res_off_in;
      status_ff   <= status_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign stat.clr_done  = &clr_ff;
   assign stat.bad_size  = (size_ff == '0) || (32'(size_ff) > (32'(1) << PO));
   assign stat.no_level  = !fit_found;
   assign stat.at_k      = (lvl_ff == k_ff);
   assign stat.scan_hit  = |hit_vec;
   assign stat.bad_off   = ((32'(offset_ff) >> PO) != '0) || offset_ff[0];
   assign stat.gran_bad  = (gran_rdata == '0) || (32'(gran_rdata) > 32'(PO));
   assign stat.at_top    = (32'(lvl_ff) == 32'(PO));
   assign stat.node_free = map_rdata[node_bit];
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_status       = rsp_stat_ff;

endmodule

>>> rtl/core/buddy_allocator_core.sv
// Top level of the buddy allocator: controller, datapath and stream ports.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_tvalid/req_tready | tuser func, tdata size and offset
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata block offset and status
//
// One item is worked on at a time; the next is taken in the cycle after the result is loaded.
// A free merges the block with its free buddy, level by level, until the buddy is in use or
// the whole pool is reached; a bad offset is answered without a merge. An allocate scans the
// node map one 32-bit row at a time and splits the block found down to the asked size; a bad
// size or no space is answered without a scan. After reset the granule store is cleared with
// req_tready low. A stalled result holds in the output register.
module buddy_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // req_size [10:0], req_offset [20:11], zero pad
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // block_offset [9:0], status [11:10], zero pad
);

   ba_pkg::ba_cmd_type  cmd;
   ba_pkg::ba_stat_type stat;
   logic [ba_pkg::OFF_W-1:0]  rsp_block_offset;
   logic [ba_pkg::STAT_W-1:0] rsp_status;

   ba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_tuser),
      .req_size         (req_tdata[10:0]),
      .req_offset       (req_tdata[20:11]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_block_offset (rsp_block_offset),
      .rsp_status       (rsp_status)
   );

   assign rsp_tdata = {4'b0000, rsp_status, rsp_block_offset};

endmodule

>>> rtl/core/ba_checker.sv
// Port-level checker of the buddy allocator and its bind to the top level.
`include "buddy_allocator_core_assert.svh"

module ba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   `BA_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result item changed while stalled")
   `BA_ASSERT(a_one_at_a_time, (req_tvalid && req_tready) |=> !req_tready, "request taken while another is at work")
   `BA_ASSERT(a_fail_zero_offset, (rsp_tvalid && rsp_tdata[11:10] != ba_pkg::ST_OK) |-> (rsp_tdata[9:0] == 10'd0), "failed result carries an offset")
   `BA_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!req_tready && !rsp_tvalid), "ports active right after reset")

endmodule

bind buddy_allocator_core ba_checker u_ba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
